FILE: design/positional_pid_antiwindup_defines.svh
// Assertion macros used by the positional PID top level.
`ifndef POSITIONAL_PID_ANTIWINDUP_DEFINES_SVH
`define POSITIONAL_PID_ANTIWINDUP_DEFINES_SVH

// A condition that must hold in the same cycle as its trigger.
`define PPA_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define PPA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/ppa_pkg.sv
// Shared types, constants and register codes of the positional PID controller.
`timescale 1ns / 1ps

package ppa_pkg;

    // Fixed field widths of the sample and result words.
    localparam int DATA_WIDTH = 16;
    localparam int CFG_WIDTH  = 16;
    localparam int GAIN_WIDTH = 16;

    // The error is the sample difference times ten, which needs five bits more than a sample.
    localparam int ERR_WIDTH = DATA_WIDTH + 5;
    localparam logic signed [ERR_WIDTH-1:0] ERR_SCALE = ERR_WIDTH'(10);

    // Defaults for the top-level parameters.
    localparam int GAIN_FRAC_BITS_DEF = 8;
    localparam int SUM_WIDTH_DEF      = 40;

    // Configuration register indexes.
    localparam int REG_IDX_WIDTH = 3;
    localparam logic [REG_IDX_WIDTH-1:0] REG_KP_GAIN        = 3'd0;
    localparam logic [REG_IDX_WIDTH-1:0] REG_KI_GAIN        = 3'd1;
    localparam logic [REG_IDX_WIDTH-1:0] REG_KD_GAIN        = 3'd2;
    localparam logic [REG_IDX_WIDTH-1:0] REG_INTEGRAL_UPPER = 3'd3;
    localparam logic [REG_IDX_WIDTH-1:0] REG_INTEGRAL_LOWER = 3'd4;
    localparam logic [REG_IDX_WIDTH-1:0] REG_DRIVE_UPPER    = 3'd5;
    localparam logic [REG_IDX_WIDTH-1:0] REG_DRIVE_LOWER    = 3'd6;

    // Register values after reset.
    localparam logic signed [CFG_WIDTH-1:0] INTEGRAL_UPPER_RST = CFG_WIDTH'(300);
    localparam logic signed [CFG_WIDTH-1:0] INTEGRAL_LOWER_RST = CFG_WIDTH'(-300);
    localparam logic signed [CFG_WIDTH-1:0] DRIVE_UPPER_RST    = CFG_WIDTH'(1000);
    localparam logic signed [CFG_WIDTH-1:0] DRIVE_LOWER_RST    = CFG_WIDTH'(-1000);

    // Input word: one sample and its setpoint.
    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] measured_value;
        logic signed [DATA_WIDTH-1:0] setpoint_value;
    } ppa_in_t;

    // Result word: the clamped drive and the two limit flags.
    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] drive_value;
        logic                         integral_clamped;
        logic                         drive_clamped;
    } ppa_out_t;

    // Status of the bit-serial multiplier seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } ppa_mul_stat_t;

endpackage

FILE: design/ppa_bitser_mul.sv
// Bit-serial shift-and-add multiplier: signed multiplicand, unsigned multiplier.
`timescale 1ns / 1ps

module ppa_bitser_mul
    import ppa_pkg::*;
#(
    parameter int MCAND_W  = SUM_WIDTH_DEF,
    parameter int MPLIER_W = 2 * GAIN_WIDTH,
    parameter int PROD_W   = SUM_WIDTH_DEF + GAIN_WIDTH
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic signed [MCAND_W-1:0]  mcand,
    input  logic        [MPLIER_W-1:0] mplier,
    output ppa_mul_stat_t              stat,
    output logic signed [PROD_W-1:0]   product
);

    logic signed [PROD_W-1:0]   acc_reg;
    logic signed [PROD_W-1:0]   mc_reg;
    logic        [MPLIER_W-1:0] mp_reg;
    logic                       busy_reg;
    logic                       mp_zero;

    // The run ends once no set multiplier bit is left.
    assign mp_zero     = (mp_reg == '0);
    assign stat.busy   = busy_reg;
    assign stat.done   = busy_reg && mp_zero;
    assign product     = acc_reg;

    // Run flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
        end else if (stat.done) begin
            busy_reg <= 1'b0;
        end
    end

    // One multiplier bit per cycle: add the shifted multiplicand when the bit is set.
    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg <= '0;
            mc_reg  <= PROD_W'(mcand);
            mp_reg  <= mplier;
        end else if (busy_reg && !mp_zero) begin
            if (mp_reg[0]) begin
                acc_reg <= acc_reg + mc_reg;
            end
            mc_reg <= mc_reg <<< 1;
            mp_reg <= mp_reg >> 1;
        end
    end

endmodule

FILE: design/positional_pid_antiwindup.sv
// Top level of the positional PID controller with integral clamp.
// Accepts one word at a time: s_ready is high only while idle, so a new word waits until
// the last result is in the output register. The shared bit-serial multiplier takes one
// multiplier bit per cycle and stops after the highest set bit (up to 16 multiplier bits
// for each gain product and up to 32 for kp*kd times the error change).
// Reset is synchronous and active low: it clears the error sum and previous error and
// reloads the register defaults; there is no clearing pass.
`timescale 1ns / 1ps
`include "positional_pid_antiwindup_defines.svh"

module positional_pid_antiwindup
    import ppa_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
    parameter int SUM_WIDTH      = SUM_WIDTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [REG_IDX_WIDTH-1:0] cfg_wr_index,
    input  logic [CFG_WIDTH-1:0]     cfg_wr_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  ppa_in_t                  s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output ppa_out_t                 m_data
);

    // Derived widths.
    localparam int F      = GAIN_FRAC_BITS;
    localparam int F2     = 2 * GAIN_FRAC_BITS;
    localparam int DIFF_W = DATA_WIDTH + 1;
    localparam int DERR_W = ERR_WIDTH + 1;
    localparam int P_W    = GAIN_WIDTH + ERR_WIDTH;
    localparam int I_W    = SUM_WIDTH + GAIN_WIDTH;
    localparam int KPD_W  = 2 * GAIN_WIDTH;
    localparam int D_W    = KPD_W + DERR_W;
    localparam int ACC_W  = (I_W > D_W) ? I_W : D_W;
    localparam int MC_A   = (SUM_WIDTH > DERR_W) ? SUM_WIDTH : DERR_W;
    localparam int MC_W   = (MC_A > GAIN_WIDTH + 1) ? MC_A : GAIN_WIDTH + 1;
    localparam int ICL_W  = CFG_WIDTH + F;
    localparam int PI_W   = ((P_W > ICL_W) ? P_W : ICL_W) + 1;
    localparam int TOT_A  = ((PI_W + F) > D_W) ? (PI_W + F) : D_W;
    localparam int TOT_W  = ((TOT_A > CFG_WIDTH + F2) ? TOT_A : CFG_WIDTH + F2) + 1;

    // Half an output unit for round to nearest, ties up.
    localparam logic signed [TOT_W-1:0] HALF =
        (F2 > 0) ? (TOT_W'(1) <<< ((F2 > 0) ? F2 - 1 : 0)) : '0;

    // Sequencer states.
    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_ERR     = 4'd1;
    localparam logic [3:0] ST_SUM     = 4'd2;
    localparam logic [3:0] ST_MUL_P   = 4'd3;
    localparam logic [3:0] ST_MUL_I   = 4'd4;
    localparam logic [3:0] ST_ILIM_HI = 4'd5;
    localparam logic [3:0] ST_ILIM_LO = 4'd6;
    localparam logic [3:0] ST_MUL_KPD = 4'd7;
    localparam logic [3:0] ST_MUL_D   = 4'd8;
    localparam logic [3:0] ST_TOTAL   = 4'd9;
    localparam logic [3:0] ST_DLIM_HI = 4'd10;
    localparam logic [3:0] ST_DLIM_LO = 4'd11;
    localparam logic [3:0] ST_OUT     = 4'd12;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // Configuration registers.
    logic        [GAIN_WIDTH-1:0] kp_reg;
    logic        [GAIN_WIDTH-1:0] ki_reg;
    logic        [GAIN_WIDTH-1:0] kd_reg;
    logic signed [CFG_WIDTH-1:0]  iu_reg;
    logic signed [CFG_WIDTH-1:0]  il_reg;
    logic signed [CFG_WIDTH-1:0]  du_reg;
    logic signed [CFG_WIDTH-1:0]  dl_reg;

    // Controller state and working registers.
    logic signed [SUM_WIDTH-1:0] sum_reg;
    logic signed [ERR_WIDTH-1:0] prev_reg;
    logic signed [DIFF_W-1:0]    diff_reg;
    logic signed [ERR_WIDTH-1:0] err_reg;
    logic signed [DERR_W-1:0]    derr_reg;
    logic signed [P_W-1:0]       p_reg;
    logic signed [I_W-1:0]       i_reg;
    logic        [KPD_W-1:0]     kpd_reg;
    logic signed [D_W-1:0]       d_reg;
    logic signed [TOT_W-1:0]     tot_reg;
    logic                        ic_reg;
    logic                        dc_reg;
    logic                        m_valid_reg;
    ppa_out_t                    m_data_reg;

    // Combinational helpers.
    logic signed [ERR_WIDTH-1:0] err_comb;
    logic signed [DERR_W-1:0]    err_pos;
    logic signed [DERR_W-1:0]    err_neg;
    logic signed [I_W-1:0]       iu_ext;
    logic signed [I_W-1:0]       il_ext;
    logic signed [TOT_W-1:0]     du_ext;
    logic signed [TOT_W-1:0]     dl_ext;
    logic signed [ICL_W-1:0]     i_cl;
    logic signed [PI_W-1:0]      pi_sum;
    logic signed [TOT_W-1:0]     tot_comb;
    logic signed [TOT_W-1:0]     rnd_sum;
    logic signed [TOT_W-1:0]     rnd_shift;
    logic                        out_free;

    // Multiplier interface.
    logic                     in_mul;
    logic                     mul_start;
    logic signed [MC_W-1:0]   mul_mcand;
    logic        [KPD_W-1:0]  mul_mplier;
    ppa_mul_stat_t            mul_stat;
    logic signed [ACC_W-1:0]  mul_prod;

    // Saturating add into the running error sum.
    function automatic logic signed [SUM_WIDTH-1:0] sum_sat_add(
        input logic signed [SUM_WIDTH-1:0] s,
        input logic signed [DERR_W-1:0]    delta
    );
        logic signed [SUM_WIDTH:0] wide;
        wide = (SUM_WIDTH + 1)'(s) + (SUM_WIDTH + 1)'(delta);
        if (wide[SUM_WIDTH] != wide[SUM_WIDTH-1]) begin
            sum_sat_add = wide[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH - 1){1'b0}}}
                                          : {1'b0, {(SUM_WIDTH - 1){1'b1}}};
        end else begin
            sum_sat_add = wide[SUM_WIDTH-1:0];
        end
    endfunction

    // Error scaling, limit alignment and the final sum.
    assign err_comb  = ERR_WIDTH'(diff_reg) * ERR_SCALE;
    assign err_pos   = DERR_W'(err_reg);
    assign err_neg   = -DERR_W'(err_reg);
    assign iu_ext    = I_W'(iu_reg) <<< F;
    assign il_ext    = I_W'(il_reg) <<< F;
    assign du_ext    = TOT_W'(du_reg) <<< F2;
    assign dl_ext    = TOT_W'(dl_reg) <<< F2;
    assign i_cl      = i_reg[ICL_W-1:0];
    assign pi_sum    = PI_W'(p_reg) + PI_W'(i_cl);
    assign tot_comb  = (TOT_W'(pi_sum) <<< F) + TOT_W'(d_reg);
    assign rnd_sum   = tot_reg + HALF;
    assign rnd_shift = rnd_sum >>> F2;
    assign out_free  = !m_valid_reg || m_ready;

    // Handshake outputs.
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Operand selection for the shared multiplier.
    assign in_mul = (state_reg == ST_MUL_P) || (state_reg == ST_MUL_I) ||
                    (state_reg == ST_MUL_KPD) || (state_reg == ST_MUL_D);
    assign mul_start = in_mul && !mul_stat.busy;

    always_comb begin
        mul_mcand  = '0;
        mul_mplier = '0;
        case (state_reg)
            ST_MUL_P: begin
                mul_mcand  = MC_W'(err_reg);
                mul_mplier = KPD_W'(kp_reg);
            end
            ST_MUL_I: begin
                mul_mcand  = MC_W'(sum_reg);
                mul_mplier = KPD_W'(ki_reg);
            end
            ST_MUL_KPD: begin
                mul_mcand  = MC_W'(kp_reg);
                mul_mplier = KPD_W'(kd_reg);
            end
            ST_MUL_D: begin
                mul_mcand  = MC_W'(derr_reg);
                mul_mplier = kpd_reg;
            end
            default: begin
            end
        endcase
    end

    ppa_bitser_mul #(
        .MCAND_W  (MC_W),
        .MPLIER_W (KPD_W),
        .PROD_W   (ACC_W)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .mcand   (mul_mcand),
        .mplier  (mul_mplier),
        .stat    (mul_stat),
        .product (mul_prod)
    );

    // Next-state logic of the sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (s_valid) state_next = ST_ERR;
            ST_ERR:     state_next = ST_SUM;
            ST_SUM:     state_next = ST_MUL_P;
            ST_MUL_P:   if (mul_stat.done) state_next = ST_MUL_I;
            ST_MUL_I:   if (mul_stat.done) state_next = ST_ILIM_HI;
            ST_ILIM_HI: state_next = ST_ILIM_LO;
            ST_ILIM_LO: state_next = ST_MUL_KPD;
            ST_MUL_KPD: if (mul_stat.done) state_next = ST_MUL_D;
            ST_MUL_D:   if (mul_stat.done) state_next = ST_TOTAL;
            ST_TOTAL:   state_next = ST_DLIM_HI;
            ST_DLIM_HI: state_next = ST_DLIM_LO;
            ST_DLIM_LO: state_next = ST_OUT;
            ST_OUT:     if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // State, configuration, persistent controller state and the output valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            kp_reg      <= '0;
            ki_reg      <= '0;
            kd_reg      <= '0;
            iu_reg      <= INTEGRAL_UPPER_RST;
            il_reg      <= INTEGRAL_LOWER_RST;
            du_reg      <= DRIVE_UPPER_RST;
            dl_reg      <= DRIVE_LOWER_RST;
            sum_reg     <= '0;
            prev_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_wr_en) begin
                unique case (cfg_wr_index)
                    REG_KP_GAIN:        kp_reg <= cfg_wr_data;
                    REG_KI_GAIN:        ki_reg <= cfg_wr_data;
                    REG_KD_GAIN:        kd_reg <= cfg_wr_data;
                    REG_INTEGRAL_UPPER: iu_reg <= cfg_wr_data;
                    REG_INTEGRAL_LOWER: il_reg <= cfg_wr_data;
                    REG_DRIVE_UPPER:    du_reg <= cfg_wr_data;
                    REG_DRIVE_LOWER:    dl_reg <= cfg_wr_data;
                    default: begin
                    end
                endcase
            end

            // The sum takes the new error, and gives it back when the integral hits a limit.
            case (state_reg)
                ST_SUM: begin
                    sum_reg  <= sum_sat_add(sum_reg, err_pos);
                    prev_reg <= err_reg;
                end
                ST_ILIM_HI: if (i_reg > iu_ext) sum_reg <= sum_sat_add(sum_reg, err_neg);
                ST_ILIM_LO: if (i_reg < il_ext) sum_reg <= sum_sat_add(sum_reg, err_neg);
                default: begin
                end
            endcase

            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Working datapath registers, stepped by the sequencer.
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                diff_reg <= DIFF_W'(s_data.setpoint_value) - DIFF_W'(s_data.measured_value);
            end
            ST_ERR: begin
                err_reg <= err_comb;
            end
            ST_SUM: begin
                derr_reg <= err_pos - DERR_W'(prev_reg);
            end
            ST_MUL_P: if (mul_stat.done) p_reg <= mul_prod[P_W-1:0];
            ST_MUL_I: if (mul_stat.done) i_reg <= mul_prod[I_W-1:0];
            ST_ILIM_HI: begin
                if (i_reg > iu_ext) begin
                    i_reg  <= iu_ext;
                    ic_reg <= 1'b1;
                end else begin
                    ic_reg <= 1'b0;
                end
            end
            ST_ILIM_LO: begin
                if (i_reg < il_ext) begin
                    i_reg  <= il_ext;
                    ic_reg <= 1'b1;
                end
            end
            ST_MUL_KPD: if (mul_stat.done) kpd_reg <= mul_prod[KPD_W-1:0];
            ST_MUL_D:   if (mul_stat.done) d_reg <= mul_prod[D_W-1:0];
            ST_TOTAL: begin
                tot_reg <= tot_comb;
            end
            ST_DLIM_HI: begin
                if (tot_reg > du_ext) begin
                    tot_reg <= du_ext;
                    dc_reg  <= 1'b1;
                end else begin
                    dc_reg <= 1'b0;
                end
            end
            ST_DLIM_LO: begin
                if (tot_reg < dl_ext) begin
                    tot_reg <= dl_ext;
                    dc_reg  <= 1'b1;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_data_reg.drive_value      <= rnd_shift[DATA_WIDTH-1:0];
                    m_data_reg.integral_clamped <= ic_reg;
                    m_data_reg.drive_clamped    <= dc_reg;
                end
            end
            default: begin
            end
        endcase
    end

    // A finished word waits in the last state while the output register is occupied.
    `PPA_ASSERT_NEXT(a_out_held, aclk, aresetn, state_reg == ST_OUT && m_valid_reg && !m_ready, state_reg == ST_OUT, "result overwrote a word not yet taken")

    // With ordered limits the clamped integral lies between them.
    `PPA_ASSERT_NEXT(a_int_range, aclk, aresetn, state_reg == ST_ILIM_LO && il_reg <= iu_reg && !$past(cfg_wr_en), i_reg >= $past(il_ext) && i_reg <= $past(iu_ext), "integral outside its limits")

    // With ordered limits the clamped total lies between the drive limits.
    `PPA_ASSERT_NEXT(a_drive_range, aclk, aresetn, state_reg == ST_DLIM_LO && dl_reg <= du_reg && !$past(cfg_wr_en), tot_reg >= $past(dl_ext) && tot_reg <= $past(du_ext), "drive total outside its limits")

    // The multiplier only finishes while the sequencer waits on it.
    `PPA_ASSERT_SAME(a_mul_owned, aclk, aresetn, mul_stat.done, in_mul, "multiplier finished outside a multiply state")

endmodule
